/* rtl/abl_pkg.sv */
// Shared types and constants for the audio block level meter.
// No dependencies; imported by every module of the block.
package abl_pkg;

  localparam int SAMPLE_W = 18;
  localparam int PEAK_W   = 16;
  localparam int MSQ_W    = 31;
  localparam int CLIP_W   = 32;
  localparam int IN_W     = 4 * SAMPLE_W;
  localparam int OUT_W    = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic signed [SAMPLE_W-1:0] Q15_FULL = 18'sd32768;
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX  = 18'sd32767;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN  = -18'sd32768;

  // input kind carried in tuser
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // source_select codes
  localparam logic [1:0] SRC_LEFT   = 2'd0;
  localparam logic [1:0] SRC_RIGHT  = 2'd1;
  localparam logic [1:0] SRC_STEREO = 2'd2;
  localparam logic [1:0] SRC_MIX    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } abl_state_t;

  typedef struct packed {
    logic load;      // take a new sample
    logic acc;       // fold the magnitude into peak and its square into sum
    logic clear;     // zero peak and sum
    logic div_load;  // move the block sum into the divider
    logic div_step;  // one quotient bit
  } abl_lane_ctl_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [MSQ_W-1:0]  mean_sq;
  } abl_lane_res_t;

endpackage

/* rtl/abl_lane.sv */
// One metering lane: Q15 saturation, square, peak hold, block sum and a
// bit-serial restoring divider for the mean square. Depends on abl_pkg.
module abl_lane import abl_pkg::*; #(
  parameter int SUM_W = 36,
  parameter int CNT_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  abl_lane_ctl_t              ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [CNT_W-1:0]           divisor,
  output abl_lane_res_t              res
);

  logic signed [SAMPLE_W-1:0] samp_r;
  logic [PEAK_W-1:0]          mag_r, mag_nxt;
  logic [2*PEAK_W-1:0]        sq_r, sq_nxt;
  logic [PEAK_W-1:0]          peak_r, peak_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [SUM_W-1:0]           dvd_r, dvd_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic signed [SAMPLE_W-1:0] sat;
  logic [CNT_W:0]             trial;
  logic                       ge;

  always_comb begin
    if (samp_r > Q15_MAX) begin
      sat = Q15_MAX;
    end else if (samp_r < Q15_MIN) begin
      sat = Q15_MIN;
    end else begin
      sat = samp_r;
    end
    mag_nxt = sat[PEAK_W-1] ? (~sat[PEAK_W-1:0] + 16'd1) : sat[PEAK_W-1:0];
    sq_nxt  = {{PEAK_W{1'b0}}, mag_nxt} * {{PEAK_W{1'b0}}, mag_nxt};
  end

  always_comb begin
    peak_nxt = peak_r;
    sum_nxt  = sum_r;
    if (ctl.clear || ctl.div_load) begin
      sum_nxt = '0;
    end else if (ctl.acc) begin
      sum_nxt = sum_r + SUM_W'(sq_r);
    end
    if (ctl.clear) begin
      peak_nxt = '0;
    end else if (ctl.acc && (mag_r > peak_r)) begin
      peak_nxt = mag_r;
    end
  end

  // restoring division, dividend bits shift out the top, quotient bits in
  always_comb begin
    trial   = {rem_r, dvd_r[SUM_W-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    if (ctl.div_load) begin
      rem_nxt = '0;
      dvd_nxt = sum_r;
    end else if (ctl.div_step) begin
      rem_nxt = ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      dvd_nxt = {dvd_r[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      samp_r <= sample;
    end
    mag_r <= mag_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      sum_r  <= '0;
    end else begin
      peak_r <= peak_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign res.peak    = peak_r;
  assign res.mean_sq = dvd_r[MSQ_W-1:0];

endmodule

/* rtl/abl_merge.sv */
// Merge stage: joins both lane results and the clip count into one output
// request held in a register until taken. Depends on abl_pkg.
module abl_merge import abl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  abl_lane_res_t     left,
  input  abl_lane_res_t     right,
  input  logic [CLIP_W-1:0] clip,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);

  logic              valid_r, valid_nxt;
  logic [OUT_W-1:0]  data_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {2'b00, clip, right.mean_sq, left.mean_sq, right.peak, left.peak};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* rtl/audio_block_level_meter.sv */
// Audio block level meter top level: source select, clip counter, frame
// counter and control sequencer over two lanes. Depends on abl_pkg,
// abl_lane and abl_merge.
//
//   channel | ports                            | payload
//   in      | in_tvalid/tready/tdata/tuser/tlast | 4 samples, func, end_of_block
//   out     | out_tvalid/tready/tdata          | peaks, mean squares, clips
//   cfg     | cfg_valid/ready/index/data       | source_select, metering_enable
//
// A clear or ignored item is taken in ST_IDLE; a metered frame passes ST_SQ and
// ST_ACC. A block end then passes ST_LOAD, ST_DIV and ST_OUT; each lane has
// its own bit-serial divider, and both are stepped together by one control.
// Reset clears meters, counters and control state, not datapath registers; no clearing pass.
// A waiting result does not block input; a second block end waits for it.
module audio_block_level_meter import abl_pkg::*; #(
  parameter int MAX_BLOCK = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // codec_left, codec_right, mix_left, mix_right
  input  logic                  in_tuser,   // func
  input  logic                  in_tlast,   // end_of_block
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // peak_l, peak_r, msq_l, msq_r, clips, pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = 30 + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);

  abl_state_t        state_r, state_nxt;
  logic [1:0]        src_r;
  logic              en_r;
  logic [CNT_W-1:0]  frames_r, frames_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [CLIP_W-1:0] clip_r, clip_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              clip_hit_r, eob_r;

  logic signed [SAMPLE_W-1:0] codec_l, codec_r, mix_l, mix_r, a_sel, b_raw, b_sel;
  logic              stereo, clip_hit, in_acc, clr_acc, smp_acc, room, merge_free;
  abl_lane_ctl_t     ctl;
  abl_lane_res_t     res_l, res_r;

  assign codec_l = in_tdata[SAMPLE_W-1:0];
  assign codec_r = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign mix_l   = in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
  assign mix_r   = in_tdata[4*SAMPLE_W-1:3*SAMPLE_W];

  always_comb begin
    stereo = src_r[1];
    b_raw  = (src_r == SRC_MIX) ? mix_r : codec_r;
    case (src_r)
      SRC_MIX:   a_sel = mix_l;
      SRC_RIGHT: a_sel = codec_r;
      default:   a_sel = codec_l;
    endcase
    b_sel    = stereo ? b_raw : a_sel;
    // clip test is on the raw sample, before saturation
    clip_hit = (a_sel >= Q15_FULL) || (a_sel <= -Q15_FULL) ||
               (stereo && ((b_raw >= Q15_FULL) || (b_raw <= -Q15_FULL)));
  end

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign clr_acc   = in_acc && (in_tuser == FUNC_CLEAR);
  assign smp_acc   = in_acc && (in_tuser == FUNC_SAMPLE) && en_r;
  assign room      = frames_r < CNT_W'(MAX_BLOCK);

  always_comb begin
    state_nxt    = state_r;
    frames_nxt   = frames_r;
    clip_nxt     = clip_r;
    dcnt_nxt     = dcnt_r;
    ctl          = '0;
    ctl.load     = smp_acc;
    ctl.clear    = clr_acc;
    case (state_r)
      ST_IDLE: begin
        if (clr_acc) begin
          frames_nxt = '0;
          clip_nxt   = '0;
        end else if (smp_acc) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (room) begin
          ctl.acc    = 1'b1;
          frames_nxt = frames_r + 1'b1;
          if (clip_hit_r && (clip_r != '1)) begin
            clip_nxt = clip_r + 1'b1;
          end
        end
        state_nxt = eob_r ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        ctl.div_load = 1'b1;
        frames_nxt   = '0;
        dcnt_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (merge_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      src_r    <= SRC_LEFT;
      en_r     <= 1'b0;
      frames_r <= '0;
      clip_r   <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      frames_r <= frames_nxt;
      clip_r   <= clip_nxt;
      dcnt_r   <= dcnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE: src_r <= cfg_data;
          CFG_ENABLE: en_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      clip_hit_r <= clip_hit;
      eob_r      <= in_tlast;
    end
    if (state_r == ST_LOAD) begin
      dvs_r <= (frames_r == '0) ? CNT_W'(1) : frames_r;
    end
  end

  abl_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sample  (a_sel),
    .divisor (dvs_r),
    .res     (res_l)
  );

  abl_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sample  (b_sel),
    .divisor (dvs_r),
    .res     (res_r)
  );

  abl_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       ((state_r == ST_OUT) && merge_free),
    .left       (res_l),
    .right      (res_r),
    .clip       (clip_r),
    .free       (merge_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= CNT_W'(MAX_BLOCK))
    else $error("frame count beyond block limit");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

  a_clip_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(clr_acc)) |-> (clip_r >= $past(clip_r)))
    else $error("clip count dropped without clear");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r < DCNT_W'(SUM_W)))
    else $error("divider step count overran");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the audio block level meter: streams sample and
// clear requests, predicts peaks, block mean squares and clip counts, and
// checks every result request. Depends on abl_pkg and audio_block_level_meter.
`timescale 1ns / 1ps

module tb_top;
  import abl_pkg::*;

  localparam int BLOCK_LIMIT = 48;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] codec_l;
    logic signed [SAMPLE_W-1:0] codec_r;
    logic signed [SAMPLE_W-1:0] mix_l;
    logic signed [SAMPLE_W-1:0] mix_r;
    logic                       last;
  } frame_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_l;
    logic [PEAK_W-1:0] peak_r;
    logic [MSQ_W-1:0]  msq_l;
    logic [MSQ_W-1:0]  msq_r;
    logic [CLIP_W-1:0] clips;
  } level_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  audio_block_level_meter #(.MAX_BLOCK(BLOCK_LIMIT)) dut (.*);

  always #5 clk = ~clk;

  frame_t frames_pending[$];
  level_t levels_due[$];
  int     errors = 0;
  int     queued = 0;
  bit     calm = 1'b0;
  logic   in_taken = 1'b0;
  int     feed_gap = 0;
  int     drain_stall = 0;

  // predicted meter state and registers
  logic [1:0]      src_sel = SRC_LEFT;
  logic            meter_on = 1'b0;
  int unsigned     hold_peak_l = 0, hold_peak_r = 0;
  longint unsigned sq_acc_l = 0, sq_acc_r = 0;
  int unsigned     frame_cnt = 0;
  int unsigned     clip_cnt = 0;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic int sat_q15(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int unsigned magn(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit full_scale(input int v);
    return v >= 32768 || v <= -32768;
  endfunction

  task automatic meter_request(input frame_t f);
    int          a, b, x, y;
    bit          stereo;
    int unsigned div;
    level_t      r;
    if (f.kind == FUNC_CLEAR) begin
      hold_peak_l = 0;
      hold_peak_r = 0;
      sq_acc_l = 0;
      sq_acc_r = 0;
      frame_cnt = 0;
      clip_cnt = 0;
      return;
    end
    if (!meter_on) return;
    if (src_sel == SRC_MIX) begin
      a = $signed(f.mix_l);
      b = $signed(f.mix_r);
    end else begin
      a = (src_sel == SRC_RIGHT) ? $signed(f.codec_r) : $signed(f.codec_l);
      b = $signed(f.codec_r);
    end
    stereo = (src_sel == SRC_STEREO) || (src_sel == SRC_MIX);
    if (frame_cnt < BLOCK_LIMIT) begin
      x = sat_q15(a);
      y = stereo ? sat_q15(b) : x;
      if (magn(x) > hold_peak_l) hold_peak_l = magn(x);
      if (magn(y) > hold_peak_r) hold_peak_r = magn(y);
      sq_acc_l += longint'(magn(x)) * longint'(magn(x));
      sq_acc_r += longint'(magn(y)) * longint'(magn(y));
      if ((full_scale(a) || (stereo && full_scale(b))) && clip_cnt != 32'hFFFF_FFFF)
        clip_cnt++;
      frame_cnt++;
    end
    if (!f.last) return;
    div = (frame_cnt != 0) ? frame_cnt : 1;
    r.peak_l = hold_peak_l[PEAK_W-1:0];
    r.peak_r = hold_peak_r[PEAK_W-1:0];
    r.msq_l  = MSQ_W'(sq_acc_l / div);
    r.msq_r  = MSQ_W'(sq_acc_r / div);
    r.clips  = clip_cnt;
    levels_due.push_back(r);
    sq_acc_l = 0;
    sq_acc_r = 0;
    frame_cnt = 0;
  endtask

  // input side: next request is presented once the current one is taken, after an optional random gap
  always @(negedge clk) begin : feed
    frame_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (feed_gap > 0) begin
        feed_gap--;
        in_tvalid <= 1'b0;
      end else if (frames_pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = frames_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.mix_r, nxt.mix_l, nxt.codec_r, nxt.codec_l};
        in_tuser  <= nxt.kind;
        in_tlast  <= nxt.last;
        if (!calm && $urandom_range(0, 5) == 0) feed_gap = $urandom_range(1, 19);
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (drain_stall > 0) begin
      drain_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) drain_stall = $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin : watch
    frame_t f;
    level_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SOURCE) src_sel = cfg_data[1:0];
        else if (cfg_index == CFG_ENABLE) meter_on = cfg_data[0];
      end
      if (in_tvalid && in_tready) begin
        {f.mix_r, f.mix_l, f.codec_r, f.codec_l} = in_tdata;
        f.kind = in_tuser;
        f.last = in_tlast;
        meter_request(f);
      end
      if (out_tvalid && out_tready) begin
        got.peak_l = out_tdata[15:0];
        got.peak_r = out_tdata[31:16];
        got.msq_l  = out_tdata[62:32];
        got.msq_r  = out_tdata[93:63];
        got.clips  = out_tdata[125:94];
        if (levels_due.size() == 0) begin
          flag_mismatch("unexpected result, peak_left", got.peak_l, 0);
        end else begin
          want = levels_due.pop_front();
          if (got.peak_l != want.peak_l) flag_mismatch("peak_left", got.peak_l, want.peak_l);
          if (got.peak_r != want.peak_r) flag_mismatch("peak_right", got.peak_r, want.peak_r);
          if (got.msq_l != want.msq_l)
            flag_mismatch("mean_square_left", got.msq_l, want.msq_l);
          if (got.msq_r != want.msq_r)
            flag_mismatch("mean_square_right", got.msq_r, want.msq_r);
          if (got.clips != want.clips) flag_mismatch("clipped_frames", got.clips, want.clips);
        end
      end
    end
  end

  task automatic push_frame(input logic kind, input int cl, input int cr, input int ml,
                            input int mr, input logic last);
    frame_t f;
    f.kind = kind;
    f.codec_l = cl[SAMPLE_W-1:0];
    f.codec_r = cr[SAMPLE_W-1:0];
    f.mix_l = ml[SAMPLE_W-1:0];
    f.mix_r = mr[SAMPLE_W-1:0];
    f.last = last;
    frames_pending.push_back(f);
    queued++;
  endtask

  function automatic int rand_sample();
    int edges[10] = '{32767, 32768, -32768, -32769, 131071, -131072, 0, 1, -1, 65536};
    case ($urandom_range(0, 3))
      0: return $signed(18'($urandom));
      1: return int'($urandom_range(0, 65535)) - 32768;
      2: return edges[$urandom_range(0, 9)] + int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic queue_block();
    int len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(BLOCK_LIMIT - 3, BLOCK_LIMIT + 12)
                                       : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 39) == 0)
        push_frame(FUNC_CLEAR, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                   1'($urandom));
      push_frame(FUNC_SAMPLE, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                 i == len - 1);
    end
  endtask

  // waits until every request is taken and every result has come back
  task automatic settle();
    while (frames_pending.size() != 0 || in_tvalid || levels_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // metering off after reset: samples and block ends are ignored
    push_frame(FUNC_SAMPLE, 32768, 5, 6, 7, 1'b1);
    push_frame(FUNC_SAMPLE, -131072, 131071, -131072, 131071, 1'b0);
    push_frame(FUNC_CLEAR, 0, 0, 0, 0, 1'b1);

    write_reg(CFG_ENABLE, 2'd1);
    write_reg(CFG_SOURCE, SRC_LEFT);
    push_frame(FUNC_SAMPLE, 131071, rand_sample(), rand_sample(), rand_sample(), 1'b0);
    push_frame(FUNC_SAMPLE, -131072, rand_sample(), rand_sample(), rand_sample(), 1'b0);
    push_frame(FUNC_SAMPLE, 32767, rand_sample(), rand_sample(), rand_sample(), 1'b0);
    push_frame(FUNC_SAMPLE, 32768, rand_sample(), rand_sample(), rand_sample(), 1'b0);
    push_frame(FUNC_SAMPLE, -32768, rand_sample(), rand_sample(), rand_sample(), 1'b0);
    push_frame(FUNC_SAMPLE, -32769, rand_sample(), rand_sample(), rand_sample(), 1'b0);
    push_frame(FUNC_SAMPLE, 0, rand_sample(), rand_sample(), rand_sample(), 1'b1);
    // clear ignores its end-of-block flag
    push_frame(FUNC_CLEAR, 1, 2, 3, 4, 1'b1);
    push_frame(FUNC_SAMPLE, -12345, 0, 0, 0, 1'b1);

    write_reg(CFG_SOURCE, SRC_RIGHT);
    push_frame(FUNC_SAMPLE, 77, 32768, -131072, 131071, 1'b0);
    push_frame(FUNC_SAMPLE, -32768, -200, 5, 5, 1'b1);

    write_reg(CFG_SOURCE, SRC_STEREO);
    push_frame(FUNC_SAMPLE, 100, -32768, 0, 0, 1'b1);
    push_frame(FUNC_SAMPLE, 32768, 5, 0, 0, 1'b1);

    write_reg(CFG_SOURCE, SRC_MIX);
    push_frame(FUNC_SAMPLE, 0, 0, -131072, 131071, 1'b1);

    // switching metering off in mid-block keeps the partial block
    push_frame(FUNC_SAMPLE, 1, 2, 3000, -4000, 1'b0);
    push_frame(FUNC_SAMPLE, 1, 2, -5000, 6000, 1'b0);
    write_reg(CFG_ENABLE, 2'd0);
    push_frame(FUNC_SAMPLE, 9, 9, 32767, 32767, 1'b1);
    push_frame(FUNC_SAMPLE, 9, 9, -20000, 20000, 1'b1);
    write_reg(CFG_ENABLE, 2'd1);
    push_frame(FUNC_SAMPLE, 1, 2, 7, -8, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SOURCE, (ph < 4) ? 2'(ph) : 2'($urandom));
      write_reg(CFG_ENABLE, (ph == 5) ? 2'd0 : 2'd1);
      if (ph == 7) calm = 1'b1;
      n = queued;
      while (queued - n < ((ph == 5) ? 30 : 120)) queue_block();
    end

    settle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
